FILE: hw/rtl/dhcpo_pkg.sv
// ----------------------------------------------------------------------------
// dhcpo_pkg
// Shared types, constants and a lookup function for the DHCP option area
// parser: item structs, parse phases, status codes and the text-code table.
// ----------------------------------------------------------------------------
package dhcpo_pkg;

    // Largest option area the parser honors; longer lengths are clamped.
    localparam int AREA_MAX = 512;
    localparam int LEN_W    = 10;
    localparam logic [LEN_W-1:0] AREA_MAX_W = LEN_W'(AREA_MAX);

    // Position counter saturates at its all-ones value.
    localparam logic [8:0] POS_TOP = 9'h1FF;

    // Special option codes
    localparam logic [7:0] CODE_PAD = 8'd0;
    localparam logic [7:0] CODE_END = 8'd255;

    // Status codes
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_END     = 2'd1;
    localparam logic [1:0] ST_NO_LEN  = 2'd2;
    localparam logic [1:0] ST_OVERRUN = 2'd3;

    // Parse phase
    typedef enum logic [1:0] {
        PH_CODE,
        PH_LEN,
        PH_DATA,
        PH_STOP
    } phase_t;

    // One input item
    typedef struct packed {
        logic [7:0] area_byte;
        logic       area_start;
        logic [8:0] area_length;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic       data_valid;
        logic [7:0] option_code;
        logic [7:0] data_byte;
        logic [7:0] zeros_before;
        logic       option_last;
        logic [1:0] status;
    } out_item_t;

    // Options whose data is text: NUL bytes are held back and counted.
    function automatic logic is_text_code(input logic [7:0] code);
        logic hit;
        unique case (code)
            8'd12, 8'd14, 8'd15, 8'd17, 8'd18, 8'd40, 8'd47, 8'd56,
            8'd60, 8'd64, 8'd66, 8'd67, 8'd77, 8'd144, 8'd252: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

FILE: hw/rtl/dhcpo_in_if.sv
// ----------------------------------------------------------------------------
// dhcpo_in_if
// Valid/ready channel carrying one option area byte with its framing fields.
// ----------------------------------------------------------------------------
interface dhcpo_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] area_byte;
    logic       area_start;
    logic [8:0] area_length;

    modport source (output valid, output area_byte, output area_start,
                    output area_length, input ready);
    modport sink   (input valid, input area_byte, input area_start,
                    input area_length, output ready);
endinterface

FILE: hw/rtl/dhcpo_out_if.sv
// ----------------------------------------------------------------------------
// dhcpo_out_if
// Valid/ready channel carrying one parse result per area byte.
// ----------------------------------------------------------------------------
interface dhcpo_out_if;
    logic       valid;
    logic       ready;
    logic       data_valid;
    logic [7:0] option_code;
    logic [7:0] data_byte;
    logic [7:0] zeros_before;
    logic       option_last;
    logic [1:0] status;

    modport source (output valid, output data_valid, output option_code,
                    output data_byte, output zeros_before, output option_last,
                    output status, input ready);
    modport sink   (input valid, input data_valid, input option_code,
                    input data_byte, input zeros_before, input option_last,
                    input status, output ready);
endinterface

FILE: hw/rtl/dhcpo_core.sv
// ----------------------------------------------------------------------------
// dhcpo_core
// Parse state and single-byte step logic. On each step the byte is classified
// against the current phase, the state advances and one result is produced.
// ----------------------------------------------------------------------------
module dhcpo_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  dhcpo_pkg::in_item_t  item,
    output dhcpo_pkg::out_item_t result
);
    import dhcpo_pkg::*;

    phase_t      phase_reg,   phase_next;
    logic [7:0]  code_reg,    code_next;
    logic [7:0]  left_reg,    left_next;
    logic [7:0]  held_reg,    held_next;
    logic [8:0]  pos_reg,     pos_next;
    logic        text_reg,    text_next;

    // Base state after an optional area restart
    phase_t      ph_b;
    logic [7:0]  code_b;
    logic [7:0]  left_b;
    logic [7:0]  held_b;
    logic [8:0]  pos_b;
    logic        text_b;

    logic [LEN_W-1:0] len_c;
    logic [LEN_W-1:0] pos_w;
    logic [LEN_W-1:0] pos_plus_one;
    logic [LEN_W-1:0] pos_plus_byte;
    logic [7:0]       b;

    // Hold parse state between steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CODE;
            code_reg  <= '0;
            left_reg  <= '0;
            held_reg  <= '0;
            pos_reg   <= '0;
            text_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            code_reg  <= code_next;
            left_reg  <= left_next;
            held_reg  <= held_next;
            pos_reg   <= pos_next;
            text_reg  <= text_next;
        end
    end

    // Step one byte: next state and result
    always_comb
    begin
        b = item.area_byte;

        // Restart parsing on the first byte of an area
        if (item.area_start)
        begin
            ph_b   = PH_CODE;
            code_b = '0;
            left_b = '0;
            held_b = '0;
            pos_b  = '0;
            text_b = 1'b0;
        end
        else
        begin
            ph_b   = phase_reg;
            code_b = code_reg;
            left_b = left_reg;
            held_b = held_reg;
            pos_b  = pos_reg;
            text_b = text_reg;
        end

        // Clamp the area length
        len_c = ({1'b0, item.area_length} > AREA_MAX_W) ? AREA_MAX_W
                                                        : {1'b0, item.area_length};
        pos_w         = {1'b0, pos_b};
        pos_plus_one  = pos_w + LEN_W'(1);
        pos_plus_byte = pos_w + LEN_W'(b);

        phase_next = ph_b;
        code_next  = code_b;
        left_next  = left_b;
        held_next  = held_b;
        text_next  = text_b;
        pos_next   = (pos_b < POS_TOP) ? pos_b + 9'd1 : pos_b;

        result = '0;

        priority if (ph_b != PH_STOP && pos_w >= len_c)
        begin
            // Stop at the area end
            phase_next = PH_STOP;
        end
        else if (ph_b == PH_CODE)
        begin
            priority if (b == CODE_END)
            begin
                result.option_code = CODE_END;
                result.status      = ST_END;
                phase_next         = PH_STOP;
            end
            else if (b != CODE_PAD)
            begin
                code_next          = b;
                result.option_code = b;
                text_next          = is_text_code(b);
                held_next          = '0;
                if (pos_plus_one >= len_c)
                begin
                    result.status = ST_NO_LEN;
                    phase_next    = PH_STOP;
                end
                else
                begin
                    phase_next = PH_LEN;
                end
            end
            else
            begin
                // Skip pad
            end
        end
        else if (ph_b == PH_LEN)
        begin
            result.option_code = code_b;
            priority if (pos_plus_byte >= len_c)
            begin
                result.status = ST_OVERRUN;
                phase_next    = PH_STOP;
            end
            else if (b == 8'd0)
            begin
                result.option_last = 1'b1;
                phase_next         = PH_CODE;
            end
            else
            begin
                left_next  = b;
                phase_next = PH_DATA;
            end
        end
        else if (ph_b == PH_DATA)
        begin
            result.option_code = code_b;
            // Hold back NULs of text options, release the count with data
            if (text_b && b == 8'd0)
            begin
                held_next = (held_b != 8'hFF) ? held_b + 8'd1 : held_b;
            end
            else
            begin
                result.data_valid   = 1'b1;
                result.data_byte    = b;
                result.zeros_before = held_b;
                held_next           = '0;
            end
            if (left_b <= 8'd1)
            begin
                // Complete the option; drop trailing NULs
                result.option_last = 1'b1;
                held_next          = '0;
                left_next          = '0;
                phase_next         = PH_CODE;
            end
            else
            begin
                left_next = left_b - 8'd1;
            end
        end
        else
        begin
            // Stopped: ignore bytes until the next area start
        end
    end

endmodule

FILE: hw/rtl/dhcp_option_tlv_parser.sv
// ----------------------------------------------------------------------------
// dhcp_option_tlv_parser
// Streaming DHCP option area parser: one area byte in, one result out.
// ----------------------------------------------------------------------------
//   Channel   Dir   Handshake      Payload
//   area_in   in    valid/ready    area_byte, area_start, area_length
//   opt_out   out   valid/ready    data_valid, option_code, data_byte,
//                                  zeros_before, option_last, status
//
// One byte is accepted per cycle unless opt_out stalls; each byte is held
// in the input register and its result in the result register, set by the
// single step of the parse state between the two registers.
// Reset clears the parse state to expect a code at position 0 and empties
// both registers. A stall on opt_out holds the result register and then the
// input register; area_in.ready drops only when both are full.
// ----------------------------------------------------------------------------
module dhcp_option_tlv_parser (
    input  logic        clk,
    input  logic        rst_n,
    dhcpo_in_if.sink    area_in,
    dhcpo_out_if.source opt_out
);
    import dhcpo_pkg::*;

    logic      in_vld_reg,  in_vld_next;
    in_item_t  in_item_reg;
    logic      out_vld_reg, out_vld_next;
    out_item_t out_item_reg;
    out_item_t step_result;
    logic      advance;
    logic      step;
    logic      in_xfer;

    // Move the input stage forward when the result register is free
    assign advance       = !out_vld_reg || opt_out.ready;
    assign step          = in_vld_reg && advance;
    assign area_in.ready = !in_vld_reg || advance;
    assign in_xfer       = area_in.valid && area_in.ready;

    always_comb
    begin
        in_vld_next  = in_xfer ? 1'b1 : (in_vld_reg && !advance);
        out_vld_next = advance ? in_vld_reg : out_vld_reg;
    end

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Capture payloads on transfer and on step
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_item_reg.area_byte   <= area_in.area_byte;
            in_item_reg.area_start  <= area_in.area_start;
            in_item_reg.area_length <= area_in.area_length;
        end
        if (step)
        begin
            out_item_reg <= step_result;
        end
    end

    dhcpo_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .result (step_result)
    );

    // Drive the result channel
    assign opt_out.valid        = out_vld_reg;
    assign opt_out.data_valid   = out_item_reg.data_valid;
    assign opt_out.option_code  = out_item_reg.option_code;
    assign opt_out.data_byte    = out_item_reg.data_byte;
    assign opt_out.zeros_before = out_item_reg.zeros_before;
    assign opt_out.option_last  = out_item_reg.option_last;
    assign opt_out.status       = out_item_reg.status;

endmodule

FILE: bench/dhcp_option_tlv_parser_tb.sv
// ----------------------------------------------------------------------------
// dhcp_option_tlv_parser_tb
// Self-checking bench for the streaming DHCP option area parser. A queue of
// area bytes feeds a valid/ready driver. Each accepted byte is run through
// a behavioral parser that tracks phase, code, remaining data, held NULs and
// position, and its result is queued. A monitor compares every result
// transfer field by field with the oldest queued result. A directed opening
// is followed by random areas under three pacing schemes and one long output
// stall that backs up the input.
// ----------------------------------------------------------------------------
module dhcp_option_tlv_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dhcpo_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 330;
    localparam int DRAIN_CYCLES = 12;

    typedef enum logic [1:0] {
        PACE_RX_SLOW,
        PACE_TX_SLOW,
        PACE_FREE
    } pace_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dhcpo_in_if  area_if ();
    dhcpo_out_if opt_if ();

    dhcp_option_tlv_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .area_in (area_if),
        .opt_out (opt_if)
    );

    // Pending area bytes, and parse results still owed by the block
    in_item_t   byte_queue[$];
    out_item_t  result_queue[$];
    in_item_t   offered;
    pace_t      pace = PACE_RX_SLOW;
    int         planned = 0;
    int         mismatches = 0;
    int         quiet_cycles = 0;
    int         hold_left = 0;
    bit         held_off = 1'b0;
    logic [7:0] seq[$];

    // Parser state as seen by the bench, at its reset values
    phase_t     area_phase = PH_CODE;
    logic [7:0] opt_code = 8'd0;
    logic [7:0] data_left_cnt = 8'd0;
    logic [7:0] nul_run = 8'd0;
    logic [8:0] area_pos = 9'd0;
    logic       opt_is_text = 1'b0;

    // Clock and reset
    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic bit text_code(input logic [7:0] code);
        return code inside {8'd12, 8'd14, 8'd15, 8'd17, 8'd18, 8'd40, 8'd47, 8'd56,
                            8'd60, 8'd64, 8'd66, 8'd67, 8'd77, 8'd144, 8'd252};
    endfunction

    function automatic logic [7:0] pick_text_code();
        logic [7:0] code;
        do
            code = 8'($urandom_range(254, 1));
        while (!text_code(code));
        return code;
    endfunction

    function automatic int idle_pct(input bit sender);
        case (pace)
            PACE_RX_SLOW: return sender ? 34 : 77;
            PACE_TX_SLOW: return sender ? 77 : 34;
            default:      return 0;
        endcase
    endfunction

    // Advance the parse state by one area byte and return its result
    function automatic out_item_t parse_byte(input in_item_t it);
        out_item_t r;
        int        lim;
        int        p;
        r = '0;
        if (it.area_start)
        begin
            area_phase    = PH_CODE;
            opt_code      = 8'd0;
            data_left_cnt = 8'd0;
            nul_run       = 8'd0;
            area_pos      = 9'd0;
            opt_is_text   = 1'b0;
        end
        lim = (int'(it.area_length) > AREA_MAX) ? AREA_MAX : int'(it.area_length);
        p = int'(area_pos);

        if (area_phase != PH_STOP && p >= lim)
            area_phase = PH_STOP;
        else
        begin
            case (area_phase)
                PH_CODE:
                begin
                    if (it.area_byte == CODE_END)
                    begin
                        r.option_code = CODE_END;
                        r.status      = ST_END;
                        area_phase    = PH_STOP;
                    end
                    else if (it.area_byte != CODE_PAD)
                    begin
                        opt_code      = it.area_byte;
                        r.option_code = it.area_byte;
                        opt_is_text   = text_code(it.area_byte);
                        nul_run       = 8'd0;
                        if (p + 1 >= lim)
                        begin
                            r.status   = ST_NO_LEN;
                            area_phase = PH_STOP;
                        end
                        else
                            area_phase = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    r.option_code = opt_code;
                    if (p + int'(it.area_byte) >= lim)
                    begin
                        r.status   = ST_OVERRUN;
                        area_phase = PH_STOP;
                    end
                    else if (it.area_byte == 8'd0)
                    begin
                        r.option_last = 1'b1;
                        area_phase    = PH_CODE;
                    end
                    else
                    begin
                        data_left_cnt = it.area_byte;
                        area_phase    = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    r.option_code = opt_code;
                    // hold NULs of text options, release the count with the next byte
                    if (opt_is_text && it.area_byte == 8'd0)
                    begin
                        if (nul_run != 8'd255)
                            nul_run = nul_run + 8'd1;
                    end
                    else
                    begin
                        r.data_valid   = 1'b1;
                        r.data_byte    = it.area_byte;
                        r.zeros_before = nul_run;
                        nul_run        = 8'd0;
                    end
                    if (data_left_cnt <= 8'd1)
                    begin
                        r.option_last = 1'b1;
                        nul_run       = 8'd0;
                        data_left_cnt = 8'd0;
                        area_phase    = PH_CODE;
                    end
                    else
                        data_left_cnt = data_left_cnt - 8'd1;
                end
                default: ;
            endcase
        end

        if (area_pos != POS_TOP)
            area_pos = area_pos + 9'd1;
        return r;
    endfunction

    // Queue the first nsend bytes of body as one area; the length changes at change_at
    task automatic queue_area(input logic [7:0] body[$], input int nsend, input int decl,
                              input bit start, input int change_at, input int new_len);
        in_item_t it;
        for (int k = 0; k < nsend; k++)
        begin
            it.area_byte   = body[k];
            it.area_start  = start && (k == 0);
            it.area_length = 9'((k >= change_at) ? new_len : decl);
            byte_queue.push_back(it);
        end
        planned += (nsend < decl) ? nsend : decl;
    endtask

    // Build one random area: mostly well-formed options, some noise and truncation
    task automatic random_area(input bit long_text);
        logic [7:0] body[$];
        logic [7:0] code;
        int         decl;
        int         nsend;
        int         olen;
        int         nul_pct;
        int         r;
        int         change_at;
        int         new_len;
        bit         noise;
        bit         start;
        noise = 1'b0;
        r = $urandom_range(99);
        if (long_text)
        begin
            decl  = $urandom_range(511, 300);
            nsend = decl;
            // longest text option: all NULs but the last byte
            body.push_back(pick_text_code());
            body.push_back(8'd255);
            repeat (254) body.push_back(8'h00);
            body.push_back(8'($urandom_range(255, 1)));
        end
        else if (r < 6)
        begin
            decl  = $urandom_range(511, 0);
            nsend = $urandom_range(12, 1);
            noise = 1'b1;
        end
        else if (r < 12)
        begin
            decl  = $urandom_range(511, 256);
            nsend = $urandom_range(30, 1);
        end
        else
        begin
            decl = $urandom_range(48, 1);
            r = $urandom_range(99);
            if (r < 70)
                nsend = decl;
            else if (r < 85)
                nsend = decl + $urandom_range(3, 1);
            else
                nsend = $urandom_range(decl, 1);
        end

        while (body.size() < nsend)
        begin
            r = $urandom_range(99);
            if (noise)
                body.push_back(8'($urandom_range(255, 0)));
            else if (r < 7)
                body.push_back(CODE_PAD);
            else if (r < 11)
                body.push_back(CODE_END);
            else
            begin
                code = ($urandom_range(1) != 0) ? pick_text_code()
                                                : 8'($urandom_range(254, 1));
                r = $urandom_range(99);
                olen = (r < 70) ? $urandom_range(6, 0)
                     : (r < 95) ? $urandom_range(24, 7) : $urandom_range(255, 25);
                nul_pct = text_code(code) ? 40 : 10;
                body.push_back(code);
                body.push_back(8'(olen));
                repeat (olen)
                    body.push_back(($urandom_range(99) < nul_pct) ? 8'h00
                                                                 : 8'($urandom_range(255, 1)));
            end
        end

        start = long_text || ($urandom_range(99) >= 5);
        change_at = nsend;
        new_len = decl;
        if (!long_text && $urandom_range(99) < 8)
        begin
            change_at = $urandom_range(nsend - 1, 0);
            new_len = $urandom_range((decl + 8 > 511) ? 511 : decl + 8, 0);
        end
        queue_area(body, nsend, decl, start, change_at, new_len);
    endtask

    // Wait until every byte is transferred and every result has come back
    task automatic drain();
        while (byte_queue.size() != 0 || area_if.valid || result_queue.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        area_if.valid       = 1'b0;
        area_if.area_byte   = 8'd0;
        area_if.area_start  = 1'b0;
        area_if.area_length = 9'd0;
        opt_if.ready        = 1'b0;

        // no start after reset; pad, text option with held NULs, zero-length
        // option, plain option with NULs, end, then a byte after end
        seq = '{8'h00, 8'd12, 8'd4, 8'h74, 8'h00, 8'h00, 8'h58, 8'd3, 8'd0,
                8'd1, 8'd2, 8'h00, 8'h00, CODE_END, 8'hAA};
        queue_area(seq, 15, 20, 1'b0, 15, 20);
        // trailing NUL dropped, then a code with no room for its length
        seq = '{8'd15, 8'd2, 8'h61, 8'h00, 8'd7};
        queue_area(seq, 5, 5, 1'b1, 5, 5);
        // zero-length option filling the area, then a byte beyond it
        seq = '{8'd9, 8'd0, 8'h33};
        queue_area(seq, 3, 2, 1'b1, 3, 2);
        // data overruns the area, then an ignored byte
        seq = '{8'd200, 8'd3, 8'h44};
        queue_area(seq, 3, 4, 1'b1, 3, 4);

        while (planned < PHASE_ITEMS)
            random_area(1'b0);
        drain();

        pace = PACE_TX_SLOW;
        while (planned < 2 * PHASE_ITEMS)
            random_area(1'b0);
        drain();

        pace = PACE_FREE;
        random_area(1'b1);
        while (planned < 3 * PHASE_ITEMS)
            random_area(1'b0);
        drain();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("** dhcp_option_tlv_parser: PASSED **");
        else
            $display("** dhcp_option_tlv_parser: FAILED **");
        $finish;
    end

    // Driver: predict each finished transfer, then hold, offer or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (area_if.valid && area_if.ready)
                result_queue.push_back(parse_byte(offered));
            if (!area_if.valid || area_if.ready)
            begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= idle_pct(1'b1))
                begin
                    offered = byte_queue.pop_front();
                    area_if.valid       <= 1'b1;
                    area_if.area_byte   <= offered.area_byte;
                    area_if.area_start  <= offered.area_start;
                    area_if.area_length <= offered.area_length;
                end
                else
                    area_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transfer, then pace ready
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (opt_if.valid && opt_if.ready)
            begin
                if (result_queue.size() == 0)
                begin
                    $error("result transfer with no expected result waiting");
                    mismatches++;
                end
                else
                begin
                    want = result_queue.pop_front();
                    check_field("data_valid", 8'(want.data_valid), 8'(opt_if.data_valid));
                    check_field("option_code", want.option_code, opt_if.option_code);
                    check_field("data_byte", want.data_byte, opt_if.data_byte);
                    check_field("zeros_before", want.zeros_before, opt_if.zeros_before);
                    check_field("option_last", 8'(want.option_last), 8'(opt_if.option_last));
                    check_field("status", 8'(want.status), 8'(opt_if.status));
                end
            end
            // one long hold-off once the sender runs free, so the input backs up
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                opt_if.ready <= 1'b0;
            end
            else if (pace == PACE_FREE && !held_off)
            begin
                hold_left = HOLD_CYCLES;
                held_off = 1'b1;
                opt_if.ready <= 1'b0;
            end
            else
                opt_if.ready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    // Watchdog: end the run after too many cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((area_if.valid && area_if.ready) || (opt_if.valid && opt_if.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("** dhcp_option_tlv_parser: FAILED **");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

FILE: sim.f
hw/rtl/dhcpo_pkg.sv
hw/rtl/dhcpo_in_if.sv
hw/rtl/dhcpo_out_if.sv
hw/rtl/dhcpo_core.sv
hw/rtl/dhcp_option_tlv_parser.sv
bench/dhcp_option_tlv_parser_tb.sv
